[sv/sfp_pkg.sv]
// Package: shared types and codes for the sensor frame parser.
`default_nettype none

package sfp_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_ID       = 2'd0;
  localparam logic [1:0] REG_COUNT_TYPE_ONE = 2'd1;
  localparam logic [1:0] REG_COUNT_TYPE_TWO = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_SAMPLE = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // Sensor type codes with a configurable sample count
  localparam logic [7:0] KIND_ONE = 8'd1;
  localparam logic [7:0] KIND_TWO = 8'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] FRAME_ID_RST       = 8'd0;
  localparam logic [3:0] COUNT_TYPE_ONE_RST = 4'd3;
  localparam logic [3:0] COUNT_TYPE_TWO_RST = 4'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_id;
    logic [3:0] count_type_one;
    logic [3:0] count_type_two;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic [3:0]         sample_index;
    logic [7:0]         sensor_kind;
    logic [1:0]         status;
    logic               last_of_frame;
  } res_t;

endpackage

`default_nettype wire

[sv/sfp_if.sv]
// Interfaces: byte input channel and result output channel.
`default_nettype none

interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface sfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_value;
  logic [3:0]         sample_index;
  logic [7:0]         sensor_kind;
  logic [1:0]         status;
  logic               last_of_frame;

  modport source (output valid, output sample_value, output sample_index,
                  output sensor_kind, output status, output last_of_frame,
                  input ready);
  modport sink   (input valid, input sample_value, input sample_index,
                  input sensor_kind, input status, input last_of_frame,
                  output ready);
endinterface

`default_nettype wire

[sv/sfp_in_stage.sv]
// Input register stage: captures one stream item per transfer.
`default_nettype none

module sfp_in_stage
  import sfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Stage frees when its item moves on
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[sv/sfp_decode.sv]
// Frame decoder: phase tracking and result formation for one byte.
`default_nettype none

module sfp_decode
  import sfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  logic [1:0] phase_r,    phase_nxt;
  logic [7:0] kind_r,     kind_nxt;
  logic [7:0] low_r,      low_nxt;
  logic [3:0] count_r,    count_nxt;
  logic [3:0] expected_r, expected_nxt;
  logic [3:0] type_count;
  logic [4:0] count_inc;
  logic       sample_last;

  // Sample count announced by the type byte
  always_comb begin
    if (item.data_byte == KIND_ONE) begin
      type_count = cfg.count_type_one;
    end else if (item.data_byte == KIND_TWO) begin
      type_count = cfg.count_type_two;
    end else begin
      type_count = 4'd0;
    end
  end

  assign count_inc   = {1'b0, count_r} + 5'd1;
  assign sample_last = count_inc >= {1'b0, expected_r};

  // Next state and result
  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    low_nxt      = low_r;
    count_nxt    = count_r;
    expected_nxt = expected_r;
    res_valid    = 1'b0;
    res          = '0;
    if (item.end_of_data) begin
      res_valid         = 1'b1;
      res.last_of_frame = 1'b1;
      if (phase_r == PH_HUNT) begin
        res.status = ST_NONE;
      end else begin
        res.status = ST_TRUNC;
        if (phase_r != PH_TYPE) begin
          res.sample_index = count_r;
          res.sensor_kind  = kind_r;
        end
      end
      phase_nxt = PH_HUNT;
      count_nxt = 4'd0;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (item.data_byte == cfg.frame_id) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          kind_nxt     = item.data_byte;
          count_nxt    = 4'd0;
          expected_nxt = type_count;
          if (type_count == 4'd0) begin
            // unknown type or zero count: one empty-frame status
            res_valid         = 1'b1;
            res.sensor_kind   = item.data_byte;
            res.status        = ST_EMPTY;
            res.last_of_frame = 1'b1;
            phase_nxt         = PH_HUNT;
          end else begin
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          low_nxt   = item.data_byte;
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          res_valid         = 1'b1;
          res.sample_value  = {item.data_byte, low_r};
          res.sample_index  = count_r;
          res.sensor_kind   = kind_r;
          res.status        = ST_SAMPLE;
          res.last_of_frame = sample_last;
          if (sample_last) begin
            phase_nxt = PH_HUNT;
            count_nxt = 4'd0;
          end else begin
            phase_nxt = PH_LOW;
            count_nxt = count_inc[3:0];
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      kind_r     <= 8'd0;
      low_r      <= 8'd0;
      count_r    <= 4'd0;
      expected_r <= 4'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      low_r      <= low_nxt;
      count_r    <= count_nxt;
      expected_r <= expected_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/sfp_out_stage.sv]
// Result register stage: holds one result until its transfer.
`default_nettype none

module sfp_out_stage
  import sfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res,
  input  wire logic out_ready,
  output logic      out_valid,
  output res_t      out_res,
  output logic      can_take
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

[sv/sensor_frame_parser_core.sv]
// Top level: sensor frame parser with input and result register stages.
//
//  channel  direction  handshake        payload
//  in_ch    in         valid/ready      data_byte, end_of_data
//  out_ch   out        valid/ready      sample_value, sample_index, sensor_kind,
//                                       status, last_of_frame
//  cfg_*    in         cfg_we           cfg_index, cfg_data
//
// One byte per cycle sustained while the result register can take a result; a
// byte is captured in the input register and its result, formed by the decode
// logic between the input and result registers, is loaded into the result
// register as the byte moves on.
// Reset clears phase, sample count and both stage valid flags and loads the
// register defaults. A stalled result holds the pipeline; the input register
// still takes a byte while its slot is free.
`default_nettype none

module sensor_frame_parser_core
  import sfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  sfp_in_if.sink          in_ch,
  sfp_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t  cfg_r;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;
  logic  can_take;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_id       <= FRAME_ID_RST;
      cfg_r.count_type_one <= COUNT_TYPE_ONE_RST;
      cfg_r.count_type_two <= COUNT_TYPE_TWO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ID:       cfg_r.frame_id       <= cfg_data;
        REG_COUNT_TYPE_ONE: cfg_r.count_type_one <= cfg_data[3:0];
        REG_COUNT_TYPE_TWO: cfg_r.count_type_two <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.data_byte   = in_ch.data_byte;
  assign in_item.end_of_data = in_ch.end_of_data;

  // Item moves through decode when the result slot can take it
  assign advance = item_valid && can_take;

  sfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sfp_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .can_take  (can_take)
  );

  assign out_ch.sample_value  = out_res.sample_value;
  assign out_ch.sample_index  = out_res.sample_index;
  assign out_ch.sensor_kind   = out_res.sensor_kind;
  assign out_ch.status        = out_res.status;
  assign out_ch.last_of_frame = out_res.last_of_frame;

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for sensor_frame_parser_core: frame decoder prediction, random streams, result checks.
module tb;
  import sfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 195;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 4;

  typedef enum logic [1:0] {PH_HUNT, PH_KIND, PH_LOW, PH_HIGH} parse_phase_t;

  // Decoder state copy plus the queue of results still owed by the block
  class frame_scoreboard;
    logic [7:0]   sync_byte;
    logic [3:0]   n_one;
    logic [3:0]   n_two;
    parse_phase_t ph;
    logic [7:0]   kind;
    logic [7:0]   low;
    logic [3:0]   done;
    logic [3:0]   want_n;
    res_t         owed_q[$];
    int unsigned  n_checked;
    int unsigned  n_bad;

    function new();
      sync_byte = FRAME_ID_RST;
      n_one     = COUNT_TYPE_ONE_RST;
      n_two     = COUNT_TYPE_TWO_RST;
      ph        = PH_HUNT;
      kind      = '0;
      low       = '0;
      done      = '0;
      want_n    = '0;
      n_checked = 0;
      n_bad     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] d);
      case (idx)
        REG_FRAME_ID:       sync_byte = d;
        REG_COUNT_TYPE_ONE: n_one = d[3:0];
        REG_COUNT_TYPE_TWO: n_two = d[3:0];
        default: ;
      endcase
    endfunction

    // Advance the decoder by one transferred byte; queue the result it owes
    function void note_input(item_t it);
      res_t r;
      logic fin;
      r = '0;
      r.last_of_frame = 1'b1;
      if (it.end_of_data) begin
        // abort: no frame while hunting, truncated otherwise
        r.status = (ph == PH_HUNT) ? ST_NONE : ST_TRUNC;
        if (ph == PH_LOW || ph == PH_HIGH) begin
          r.sample_index = done;
          r.sensor_kind  = kind;
        end
        owed_q.push_back(r);
        ph   = PH_HUNT;
        done = '0;
        return;
      end
      case (ph)
        PH_HUNT: begin
          if (it.data_byte == sync_byte) ph = PH_KIND;
        end
        PH_KIND: begin
          // sample count latched from the registers here
          kind = it.data_byte;
          done = '0;
          if (it.data_byte == KIND_ONE) want_n = n_one;
          else if (it.data_byte == KIND_TWO) want_n = n_two;
          else want_n = '0;
          if (want_n == '0) begin
            r.sensor_kind = kind;
            r.status      = ST_EMPTY;
            owed_q.push_back(r);
            ph = PH_HUNT;
          end else begin
            ph = PH_LOW;
          end
        end
        PH_LOW: begin
          low = it.data_byte;
          ph  = PH_HIGH;
        end
        default: begin
          fin = (({1'b0, done} + 5'd1) >= {1'b0, want_n});
          r.sample_value  = {it.data_byte, low};
          r.sample_index  = done;
          r.sensor_kind   = kind;
          r.status        = ST_SAMPLE;
          r.last_of_frame = fin;
          owed_q.push_back(r);
          if (fin) begin
            ph   = PH_HUNT;
            done = '0;
          end else begin
            ph   = PH_LOW;
            done = done + 4'd1;
          end
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t w;
      n_checked++;
      if (owed_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("ERROR: unexpected result value=%0d index=%0d kind=%0d status=%0d last=%0d",
                   got.sample_value, got.sample_index, got.sensor_kind, got.status,
                   got.last_of_frame);
        return;
      end
      w = owed_q.pop_front();
      if (got.sample_value !== w.sample_value || got.sample_index !== w.sample_index ||
          got.sensor_kind !== w.sensor_kind || got.status !== w.status ||
          got.last_of_frame !== w.last_of_frame) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("ERROR: result %0d expected value=%0d index=%0d kind=%0d status=%0d last=%0d",
                   n_checked, w.sample_value, w.sample_index, w.sensor_kind, w.status,
                   w.last_of_frame);
          $display("ERROR: result %0d actual   value=%0d index=%0d kind=%0d status=%0d last=%0d",
                   n_checked, got.sample_value, got.sample_index, got.sensor_kind,
                   got.status, got.last_of_frame);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  sfp_in_if  in_ch ();
  sfp_out_if out_ch ();

  frame_scoreboard sb = new();

  int unsigned in_gap_max  = 3;
  int unsigned out_gap_max = 3;
  int unsigned hold_len    = 0;
  int unsigned n_items     = 0;
  int unsigned n_frames    = 0;
  int unsigned n_writes    = 0;
  int unsigned cycle_cnt   = 0;

  sensor_frame_parser_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one byte after a random gap; returns on the transfer edge
  task automatic send_item(input logic [7:0] b, input logic eod);
    item_t it;
    int unsigned gap;
    it.data_byte   = b;
    it.end_of_data = eod;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_data <= eod;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    n_items++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, d);
    n_writes++;
  endtask

  // Stop offering, let every owed result arrive, then let the pipe empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, some noise and aborts
  task automatic send_frame();
    int unsigned r;
    int unsigned cnt;
    int unsigned cut;
    int unsigned i;
    logic [7:0] kb;
    logic [7:0] nb;
    n_frames++;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      send_item(rand_byte(), 1'b1);
      return;
    end
    if (r == 1) begin
      send_item(rand_byte(), 1'b0);
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        nb = rand_byte();
        if (nb == sb.sync_byte) nb = ~nb;
        send_item(nb, 1'b0);
      end
    end
    send_item(sb.sync_byte, 1'b0);
    if ($urandom_range(0, 15) == 0) begin
      send_item(rand_byte(), 1'b1);
      return;
    end
    r = $urandom_range(0, 9);
    if (r < 4) kb = KIND_ONE;
    else if (r < 8) kb = KIND_TWO;
    else kb = rand_byte();
    if (kb == KIND_ONE) cnt = int'(sb.n_one);
    else if (kb == KIND_TWO) cnt = int'(sb.n_two);
    else cnt = 0;
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2 * cnt) : 2 * cnt + 1;
    send_item(kb, 1'b0);
    for (i = 0; i < 2 * cnt; i++) begin
      if (i == cut) begin
        send_item(rand_byte(), 1'b1);
        return;
      end
      send_item(rand_byte(), 1'b0);
    end
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    res_t got;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.sample_value  = out_ch.sample_value;
      got.sample_index  = out_ch.sample_index;
      got.sensor_kind   = out_ch.sensor_kind;
      got.status        = out_ch.status;
      got.last_of_frame = out_ch.last_of_frame;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned start;
    logic [7:0] fid;
    logic [3:0] c1;
    logic [3:0] c2;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.end_of_data <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_FRAME_ID;
    cfg_data          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: abort while hunting, abort before the type byte
    send_item(8'hA5, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5A, 1'b1);
    // type one, three samples at zero, max and min
    send_item(8'h00, 1'b0);
    send_item(KIND_ONE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    // sync byte as the type, then an unknown type: both empty frames
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // sync byte as sample data, then truncation mid-frame
    send_item(8'h00, 1'b0);
    send_item(KIND_TWO, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hC3, 1'b1);
    // count latched at the type byte: a later write must not shorten the frame
    send_item(8'h00, 1'b0);
    send_item(KIND_ONE, 1'b0);
    drain();
    write_reg(REG_COUNT_TYPE_ONE, 8'h01);
    send_item(8'h34, 1'b0);
    send_item(8'h12, 1'b0);
    send_item(8'h00, 1'b1);
    // known type with a zero count gives an empty frame
    drain();
    write_reg(REG_COUNT_TYPE_TWO, 8'hF0);
    send_item(8'h00, 1'b0);
    send_item(KIND_TWO, 1'b0);

    // Random phases over several register settings, extremes first
    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin fid = 8'hFF; c1 = 4'd15; c2 = 4'd0;  end
        1: begin fid = 8'h00; c1 = 4'd0;  c2 = 4'd15; end
        2: begin fid = rand_byte(); c1 = 4'd1; c2 = 4'd1; end
        default: begin
          fid = rand_byte();
          c1  = 4'($urandom_range(0, 15));
          c2  = 4'($urandom_range(0, 15));
        end
      endcase
      write_reg(REG_FRAME_ID, fid);
      write_reg(REG_COUNT_TYPE_ONE, {4'($urandom_range(0, 15)), c1});
      write_reg(REG_COUNT_TYPE_TWO, {4'($urandom_range(0, 15)), c2});
      in_gap_max  = (p == 3 || p == 5) ? 0 : 11;
      out_gap_max = (p == 4 || p == 5) ? 0 : 11;
      // long receiver hold-off with the sender streaming: block fills and stalls
      if (p == 5) hold_len = HOLD_CYCLES;
      start = n_items;
      while (n_items - start < ITEMS_PER_PHASE) send_frame();
    end

    drain();
    out_gap_max = 0;
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("covered %0d byte transfers in %0d generated frames, %0d register writes",
             n_items, n_frames, n_writes);
    $display("checked %0d results, %0d mismatches", sb.n_checked, sb.n_bad);
    if (sb.n_bad == 0 && sb.owed_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sensor_frame_parser_core.f]
sv/sfp_pkg.sv
sv/sfp_if.sv
sv/sfp_in_stage.sv
sv/sfp_decode.sv
sv/sfp_out_stage.sv
sv/sensor_frame_parser_core.sv
sim/tb.sv
